// File: src/tshd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tshd_pkg: shared types and codes for the tar stream header deframer
// Result kinds, entry classes and the result beat carried front to back.
// ---------------------------------------------------------------------------
package tshd_pkg;

    localparam logic [2:0] KIND_HEADER   = 3'd0;
    localparam logic [2:0] KIND_DATA     = 3'd1;
    localparam logic [2:0] KIND_END      = 3'd2;
    localparam logic [2:0] KIND_CHKERR   = 3'd3;
    localparam logic [2:0] KIND_METABIG  = 3'd4;

    localparam logic [2:0] ET_FILE    = 3'd0;
    localparam logic [2:0] ET_DIR     = 3'd1;
    localparam logic [2:0] ET_SYMLINK = 3'd2;
    localparam logic [2:0] ET_HARD    = 3'd3;
    localparam logic [2:0] ET_OTHER   = 3'd4;

    localparam logic [31:0] META_LIMIT_RESET = 32'h0010_0000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  etype;
        logic [7:0]  tbyte;
        logic [63:0] ssize;
        logic [63:0] rsize;
        logic [31:0] mode;
        logic [31:0] uid;
        logic [31:0] gid;
        logic [63:0] mtime;
        logic [7:0]  pbyte;
        logic        last;
    } result_t;

    function automatic logic [2:0] classify(input logic [7:0] t);
        priority if (t == 8'h35) classify = ET_DIR;
        else if (t == 8'h30 || t == 8'h00 || t == 8'h53) classify = ET_FILE;
        else if (t == 8'h32) classify = ET_SYMLINK;
        else if (t == 8'h31) classify = ET_HARD;
        else classify = ET_OTHER;
    endfunction

endpackage

// File: src/tshd_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tshd_front: byte parser
// Walks the block structure, decodes header fields and emits result beats.
// ---------------------------------------------------------------------------
module tshd_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [7:0]       in_byte,
    input  logic [31:0]      meta_limit,
    output logic             accept,
    input  logic             q_full,
    output logic             res_valid,
    output tshd_pkg::result_t res
);
    import tshd_pkg::*;

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_DATA   = 3'd1;
    localparam logic [2:0] PH_PAD    = 3'd2;
    localparam logic [2:0] PH_META   = 3'd3;
    localparam logic [2:0] PH_EXT    = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    logic [2:0]  phase_reg, phase_next;
    logic [8:0]  off_reg, off_next;
    logic [16:0] sum_reg, sum_next;
    logic        zero_reg, zero_next;
    logic [63:0] acc_reg, acc_next;
    logic        b256_reg, b256_next, started_reg, started_next, stopped_reg, stopped_next;
    logic [63:0] size_reg, size_next, sparse_reg, sparse_next, time_reg, time_next;
    logic [31:0] mode_reg, mode_next, uid_reg, uid_next, gid_reg, gid_next, chk_reg, chk_next;
    logic [7:0]  type_reg, type_next;
    logic        ext_reg, ext_next;
    logic [63:0] rem_reg, rem_next;

    // field lookup by offset
    logic        in_fld, fld_len8, fld_first, fld_last;
    logic [2:0]  fld_id;
    always_comb
    begin
        in_fld = 1'b1; fld_len8 = 1'b1; fld_first = 1'b0; fld_last = 1'b0; fld_id = 3'd0;
        priority if (off_reg >= 9'd100 && off_reg < 9'd108)
        begin
            fld_id = 3'd0; fld_first = off_reg == 9'd100; fld_last = off_reg == 9'd107;
        end
        else if (off_reg >= 9'd108 && off_reg < 9'd116)
        begin
            fld_id = 3'd1; fld_first = off_reg == 9'd108; fld_last = off_reg == 9'd115;
        end
        else if (off_reg >= 9'd116 && off_reg < 9'd124)
        begin
            fld_id = 3'd2; fld_first = off_reg == 9'd116; fld_last = off_reg == 9'd123;
        end
        else if (off_reg >= 9'd124 && off_reg < 9'd136)
        begin
            fld_id = 3'd3; fld_len8 = 1'b0;
            fld_first = off_reg == 9'd124; fld_last = off_reg == 9'd135;
        end
        else if (off_reg >= 9'd136 && off_reg < 9'd148)
        begin
            fld_id = 3'd4; fld_len8 = 1'b0;
            fld_first = off_reg == 9'd136; fld_last = off_reg == 9'd147;
        end
        else if (off_reg >= 9'd148 && off_reg < 9'd156)
        begin
            fld_id = 3'd5; fld_first = off_reg == 9'd148; fld_last = off_reg == 9'd155;
        end
        else if (off_reg >= 9'd483 && off_reg < 9'd495)
        begin
            fld_id = 3'd6; fld_len8 = 1'b0;
            fld_first = off_reg == 9'd483; fld_last = off_reg == 9'd494;
        end
        else in_fld = 1'b0;
    end

    assign accept = in_valid && !q_full;

    logic [63:0] acc_base, fval;
    logic        b_oct, b_blank, f_b256, f_st, f_sp;
    logic [63:0] hstored, hreal;
    logic [63:0] meta_round;
    logic        last_off;

    always_comb
    begin
        phase_next = phase_reg; off_next = off_reg; sum_next = sum_reg; zero_next = zero_reg;
        acc_next = acc_reg; b256_next = b256_reg; started_next = started_reg;
        stopped_next = stopped_reg; size_next = size_reg; sparse_next = sparse_reg;
        time_next = time_reg; mode_next = mode_reg; uid_next = uid_reg; gid_next = gid_reg;
        chk_next = chk_reg; type_next = type_reg; ext_next = ext_reg; rem_next = rem_reg;
        res_valid = 1'b0; res = '0;
        b_oct = in_byte >= 8'd48 && in_byte <= 8'd55;
        b_blank = in_byte == 8'd0 || in_byte == 8'd32;
        acc_base = acc_reg; f_b256 = b256_reg; f_st = started_reg; f_sp = stopped_reg;
        fval = '0; hstored = '0; hreal = '0;
        meta_round = (size_reg + 64'd511) & ~64'd511;
        last_off = off_reg == 9'd511;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    sum_next = ((off_reg == 9'd0) ? 17'd0 : sum_reg)
                             + ((off_reg >= 9'd148 && off_reg < 9'd156) ? 17'd32
                                                                        : {9'd0, in_byte});
                    zero_next = ((off_reg == 9'd0) ? 1'b1 : zero_reg) && in_byte == 8'd0;
                    // numeric field decode
                    if (in_fld)
                    begin
                        if (fld_first)
                        begin
                            acc_base = '0; f_b256 = 1'b0; f_st = 1'b0; f_sp = 1'b0;
                        end
                        if (fld_first && fld_id != 3'd5 && in_byte[7])
                        begin
                            f_b256 = 1'b1; acc_base = {57'd0, in_byte[6:0]};
                        end
                        else if (!fld_first && f_b256)
                            acc_base = {acc_base[55:0], in_byte};
                        else if (!f_sp && !(!f_st && b_blank))
                        begin
                            f_st = 1'b1;
                            if (b_oct) acc_base = {acc_base[60:0], in_byte[2:0]};
                            else f_sp = 1'b1;
                        end
                        acc_next = acc_base; b256_next = f_b256;
                        started_next = f_st; stopped_next = f_sp;
                        fval = acc_base;
                        if (f_b256 && fld_len8 && acc_base[62]) fval[63] = 1'b1;
                        if (fld_last)
                        begin
                            unique case (fld_id)
                                3'd0: mode_next = fval[31:0];
                                3'd1: uid_next = fval[31:0];
                                3'd2: gid_next = fval[31:0];
                                3'd3: size_next = fval;
                                3'd4: time_next = fval;
                                3'd5: chk_next = fval[31:0];
                                default: sparse_next = fval;
                            endcase
                        end
                    end
                    if (off_reg == 9'd156) type_next = in_byte;
                    if (off_reg == 9'd482) ext_next = in_byte == 8'd49;
                    off_next = off_reg + 9'd1;
                    // end of header block
                    if (last_off)
                    begin
                        off_next = '0;
                        res_valid = 1'b1;
                        if (zero_next)
                        begin
                            phase_next = PH_DONE; res.kind = KIND_END;
                        end
                        else if (sum_next != chk_reg[16:0] || chk_reg[31:17] != 15'd0)
                        begin
                            phase_next = PH_DONE; res.kind = KIND_CHKERR;
                        end
                        else if (type_reg == 8'h78 || type_reg == 8'h67 ||
                                 type_reg == 8'h4c || type_reg == 8'h4b)
                        begin
                            if (size_reg > {32'd0, meta_limit})
                            begin
                                phase_next = PH_DONE; res.kind = KIND_METABIG;
                            end
                            else
                            begin
                                res_valid = 1'b0;
                                rem_next = meta_round;
                                phase_next = (meta_round != 64'd0) ? PH_META : PH_HEADER;
                            end
                        end
                        else
                        begin
                            hstored = size_reg; hreal = size_reg;
                            if (type_reg == 8'h53 && sparse_reg != 64'd0) hreal = sparse_reg;
                            if (type_reg == 8'h31)
                            begin
                                hstored = '0; hreal = '0;
                            end
                            size_next = hstored;
                            res.kind = KIND_HEADER; res.etype = classify(type_reg);
                            res.tbyte = type_reg; res.ssize = hstored; res.rsize = hreal;
                            res.mode = mode_reg; res.uid = uid_reg; res.gid = gid_reg;
                            res.mtime = time_reg;
                            if (type_reg == 8'h53 && ext_next) phase_next = PH_EXT;
                            else if (hstored != 64'd0)
                            begin
                                rem_next = hstored; phase_next = PH_DATA;
                            end
                            else phase_next = PH_HEADER;
                        end
                    end
                end
                PH_DATA:
                begin
                    res_valid = 1'b1; res.kind = KIND_DATA; res.pbyte = in_byte;
                    off_next = off_reg + 9'd1;
                    rem_next = rem_reg - 64'd1;
                    if (rem_reg == 64'd1)
                    begin
                        res.last = 1'b1;
                        phase_next = (off_next == 9'd0) ? PH_HEADER : PH_PAD;
                    end
                end
                PH_PAD:
                begin
                    off_next = off_reg + 9'd1;
                    if (last_off) phase_next = PH_HEADER;
                end
                PH_META:
                begin
                    rem_next = rem_reg - 64'd1;
                    if (rem_reg == 64'd1)
                    begin
                        off_next = '0; phase_next = PH_HEADER;
                    end
                end
                PH_EXT:
                begin
                    if (off_reg == 9'd504) ext_next = in_byte == 8'd49;
                    off_next = off_reg + 9'd1;
                    if (last_off && !ext_next)
                    begin
                        if (size_reg != 64'd0)
                        begin
                            rem_next = size_reg; phase_next = PH_DATA;
                        end
                        else phase_next = PH_HEADER;
                    end
                end
                default: ;
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER; off_reg <= '0; sum_reg <= '0; zero_reg <= 1'b1;
            acc_reg <= '0; b256_reg <= 1'b0; started_reg <= 1'b0; stopped_reg <= 1'b0;
            size_reg <= '0; sparse_reg <= '0; time_reg <= '0; mode_reg <= '0;
            uid_reg <= '0; gid_reg <= '0; chk_reg <= '0; type_reg <= '0;
            ext_reg <= 1'b0; rem_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next; off_reg <= off_next; sum_reg <= sum_next;
            zero_reg <= zero_next; acc_reg <= acc_next; b256_reg <= b256_next;
            started_reg <= started_next; stopped_reg <= stopped_next;
            size_reg <= size_next; sparse_reg <= sparse_next; time_reg <= time_next;
            mode_reg <= mode_next; uid_reg <= uid_next; gid_reg <= gid_next;
            chk_reg <= chk_next; type_reg <= type_next; ext_reg <= ext_next;
            rem_reg <= rem_next;
        end
    end

    // a finished stream never produces more beats
    a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DONE |-> !res_valid) else $error("beat after end");
    a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> rem_reg != 64'd0) else $error("data with zero count");
    a_no_res_stall: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> accept) else $error("beat without accept");

endmodule

// File: src/tshd_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tshd_queue: two-entry result queue
// Parts the parser from the output so each side stalls on its own.
// ---------------------------------------------------------------------------
module tshd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  tshd_pkg::result_t wr_data,
    output logic              full,
    output logic              rd_valid,
    input  logic              rd_stall,
    output tshd_pkg::result_t rd_data
);
    import tshd_pkg::*;

    result_t   mem_reg [2];
    logic      wp_reg, rp_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic      rd_en;

    assign full = cnt_reg == 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data = mem_reg[rp_reg];
    assign rd_en = rd_valid && !rd_stall;
    assign cnt_next = cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};

    // payload storage
    always_ff @(posedge clk)
    begin
        if (wr_en) mem_reg[wp_reg] <= wr_data;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= '0;
        end
        else
        begin
            if (wr_en) wp_reg <= ~wp_reg;
            if (rd_en) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !wr_en) else $error("queue overflow");

endmodule

// File: src/tar_stream_header_deframer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tar_stream_header_deframer: archive byte stream deframer
// One byte per cycle while in_stall is low; result beats leave through a two-entry queue.
// Each result beat is written into the queue registers as the byte that causes it is accepted.
// in_stall is raised while the queue is full, which holds back the next byte.
// Reset: rst_n clears parser state and queue; limit returns to 1 MiB.
// ---------------------------------------------------------------------------
module tar_stream_header_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  result_kind,
    output logic [2:0]  entry_type,
    output logic [7:0]  type_byte,
    output logic [63:0] entry_size,
    output logic [63:0] logical_size,
    output logic [31:0] file_mode,
    output logic [31:0] owner_id,
    output logic [31:0] group_id,
    output logic [63:0] mod_time,
    output logic [7:0]  payload_byte,
    output logic        last_payload
);
    import tshd_pkg::*;

    logic [31:0] limit_reg;
    logic        accept, q_full, res_valid;
    result_t     res, qout;

    assign cfg_ready = 1'b1;
    // limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) limit_reg <= META_LIMIT_RESET;
        else if (cfg_valid) limit_reg <= cfg_data;
    end

    tshd_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_byte(data_byte),
        .meta_limit(limit_reg), .accept(accept), .q_full(q_full),
        .res_valid(res_valid), .res(res)
    );

    tshd_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_en(res_valid), .wr_data(res), .full(q_full),
        .rd_valid(out_valid), .rd_stall(out_stall), .rd_data(qout)
    );

    assign in_stall = q_full;
    assign result_kind = qout.kind;
    assign entry_type = qout.etype;
    assign type_byte = qout.tbyte;
    assign entry_size = qout.ssize;
    assign logical_size = qout.rsize;
    assign file_mode = qout.mode;
    assign owner_id = qout.uid;
    assign group_id = qout.gid;
    assign mod_time = qout.mtime;
    assign payload_byte = qout.pbyte;
    assign last_payload = qout.last;

    a_accept_match: assert property (@(posedge clk) disable iff (!rst_n)
        accept == (in_valid && !in_stall)) else $error("accept mismatch");

endmodule
